// ===== rtl/tdpf_pkg.sv =====
// Package: shared types and constants of the two-distinct-prime counter.
package tdpf_pkg;

  localparam int LIMIT_W = 12;
  localparam int COUNT_W = 12;
  localparam int TALLY_W = 2;

  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [TALLY_W-1:0] tally_t;

  // Tally saturates here; a query counts entries equal to the wanted value
  localparam tally_t TALLY_SAT      = 2'd3;
  localparam tally_t WANTED_FACTORS = 2'd2;
  localparam tally_t TALLY_ZERO     = 2'd0;

  // Smallest index a scan looks at
  localparam int FIRST_INDEX = 2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_PRIME_RD,
    ST_PRIME_CHK,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/tdpf_if.sv =====
// Interfaces: query channel and result channel, valid/ready handshake.
interface tdpf_in_if;
  logic             valid;
  logic             ready;
  tdpf_pkg::limit_t limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

interface tdpf_out_if;
  logic             valid;
  logic             ready;
  tdpf_pkg::count_t count;

  modport source (output valid, output count, input ready);
  modport sink   (input valid, input count, output ready);
endinterface

// ===== rtl/tdpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module tdpf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read; read data is registered and appears in the cycle after the address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/two_distinct_prime_factor_count.sv =====
// Top level: sieve-built factor table and a scanning query engine.
// After reset the block clears its factor table and then runs a sieve over
// it: for each prime candidate it reads and checks the table entry, and for
// each prime it reads and writes back every multiple to raise its tally; no
// query is taken until the table is built.
// A query with limit n then scans the table from index 2 to min(n, MAX_N-1)
// through the one read port of the table memory, one entry per cycle, and
// then registers its count as the result; limits below 2 skip the scan and
// give zero. One query is in work at a time; the result waits in an output
// register while the next query is taken.
module two_distinct_prime_factor_count #(
  parameter int MAX_N = 4096
) (
  input  logic   clk,
  input  logic   rst_n,
  tdpf_in_if.sink    in_ch,
  tdpf_out_if.source out_ch
);

  import tdpf_pkg::*;

  localparam int AW = $clog2(MAX_N);
  localparam int PW = AW + 1;
  localparam int LW = (AW > LIMIT_W) ? AW : LIMIT_W;
  localparam logic [PW-1:0] MAX_P   = PW'(MAX_N);
  localparam logic [LW-1:0] LAST_IX = LW'(MAX_N - 1);

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [PW-1:0]   m_r, m_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic [AW-1:0]   lim_r, lim_nxt;
  count_t          cnt_r, cnt_nxt;
  logic            chk_r, chk_nxt;
  logic            out_valid_r, out_valid_nxt;
  count_t          out_count_r, out_count_nxt;

  logic            we;
  logic [AW-1:0]   waddr;
  tally_t          wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  tally_t          rdata;
  logic [LW-1:0]   lim_ext;
  logic [LW-1:0]   lim_eff;

  tdpf_ram #(
    .WIDTH (TALLY_W),
    .DEPTH (MAX_N)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Saturate the limit at the last table index
  assign lim_ext = LW'(in_ch.limit);
  assign lim_eff = (lim_ext > LAST_IX) ? LAST_IX : lim_ext;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.count = out_count_r;

  // Hold state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r         <= p_nxt;
    m_r         <= m_nxt;
    i_r         <= i_nxt;
    lim_r       <= lim_nxt;
    cnt_r       <= cnt_nxt;
    out_count_r <= out_count_nxt;
  end

  // Next state: clear, sieve, then serve queries
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    lim_nxt       = lim_r;
    cnt_nxt       = cnt_r;
    chk_nxt       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_count_nxt = out_count_r;
    we            = 1'b0;
    waddr         = clr_r;
    wdata         = TALLY_ZERO;
    re            = 1'b0;
    raddr         = i_r;

    // Count a scanned entry whose read data arrives this cycle
    if (chk_r && (rdata == WANTED_FACTORS)) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = TALLY_ZERO;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MAX_N - 1)) begin
          p_nxt     = PW'(FIRST_INDEX);
          state_nxt = ST_PRIME_RD;
        end
      end
      ST_PRIME_RD: begin
        if (p_r == MAX_P) begin
          state_nxt = ST_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = p_r[AW-1:0];
          state_nxt = ST_PRIME_CHK;
        end
      end
      ST_PRIME_CHK: begin
        // Untouched entry means no smaller prime divides it
        if (rdata == TALLY_ZERO) begin
          m_nxt     = p_r;
          state_nxt = ST_MARK_RD;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = ST_PRIME_RD;
        end
      end
      ST_MARK_RD: begin
        if (m_r < MAX_P) begin
          re        = 1'b1;
          raddr     = m_r[AW-1:0];
          state_nxt = ST_MARK_WR;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = ST_PRIME_RD;
        end
      end
      ST_MARK_WR: begin
        we        = 1'b1;
        waddr     = m_r[AW-1:0];
        wdata     = (rdata == TALLY_SAT) ? TALLY_SAT : rdata + 1'b1;
        m_nxt     = m_r + p_r;
        state_nxt = ST_MARK_RD;
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          cnt_nxt = '0;
          lim_nxt = lim_eff[AW-1:0];
          i_nxt   = AW'(FIRST_INDEX);
          if (lim_eff < LW'(FIRST_INDEX)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        re      = 1'b1;
        raddr   = i_r;
        chk_nxt = 1'b1;
        i_nxt   = i_r + 1'b1;
        if (i_r == lim_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Last read data is counted this cycle
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

endmodule
